/* src/lsfa_pkg.sv */
// ---------------------------------------------------------------------------
// lsfa_pkg: shared types and constants for the spline fit accumulator
// Holds sizes, action and register codes, and the saturating add.
// ---------------------------------------------------------------------------
`default_nettype none

package lsfa_pkg;

    localparam int MAX_KNOTS  = 32;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_KNOTS);
    localparam int SUM_W      = 56;
    localparam int CNT_W      = 20;
    localparam int HGT_W      = 24;
    localparam int WGT_W      = 17;                 // Q1.16, up to 1.0
    localparam int PRD_W      = 2 * WGT_W;          // widest increment
    localparam int DIV_W      = COORD_BITS + 16;    // offset * 2^16
    localparam int SP_W       = 12;
    localparam int TOL_W      = 20;
    localparam int CFG_W      = 20;
    localparam int CFG_A_W    = 3;
    localparam int DIFF_W     = 44;

    typedef logic [1:0] t_action;
    localparam t_action ACT_PIXEL = 2'd0;
    localparam t_action ACT_CLEAR = 2'd1;
    localparam t_action ACT_LOAD  = 2'd2;
    localparam t_action ACT_READ  = 2'd3;

    typedef logic [CFG_A_W-1:0] t_cfg_addr;
    localparam t_cfg_addr REG_SPACING  = 3'd0;
    localparam t_cfg_addr REG_SEGMENTS = 3'd1;
    localparam t_cfg_addr REG_TOL      = 3'd2;
    localparam t_cfg_addr REG_XBOUND   = 3'd3;
    localparam t_cfg_addr REG_YBOUND   = 3'd4;

    // one knot's sums as kept in the sum memory
    typedef struct packed {
        logic [SUM_W-1:0] diag;
        logic [SUM_W-1:0] offd;
        logic [SUM_W-1:0] rhs;
    } t_sums;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PRD_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - PRD_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/lsfa_div.sv */
// ---------------------------------------------------------------------------
// lsfa_div: restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lsfa_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [lsfa_pkg::SP_W-1:0]     i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [lsfa_pkg::DIV_W-1:0]         o_quotient,
    output logic [lsfa_pkg::SP_W-1:0]          o_remainder
);
    import lsfa_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]    r_quo;
    logic [SP_W-1:0]     r_rem;
    logic [SP_W-1:0]     r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_run;
    logic                r_done;
    logic [SP_W:0]       rem_sh;
    logic                ge;

    // one restoring step
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_BITS'(DIV_W);
                r_quo <= i_dividend;
                r_rem <= '0;
                r_den <= i_divisor;
            end else if (r_run) begin
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_rem <= ge ? SP_W'(rem_sh - {1'b0, r_den}) : rem_sh[SP_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_run;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

/* src/lsfa_knot_mem.sv */
// ---------------------------------------------------------------------------
// lsfa_knot_mem: knot height memory
// One write and one registered read port; unwritten entries read as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfa_knot_mem (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [lsfa_pkg::IDX_W-1:0]        i_waddr,
    input  wire logic signed [lsfa_pkg::HGT_W-1:0] i_wdata,
    input  wire logic [lsfa_pkg::IDX_W-1:0]        i_raddr,
    output logic signed [lsfa_pkg::HGT_W-1:0]      o_rdata
);
    import lsfa_pkg::*;

    logic signed [HGT_W-1:0] mem [MAX_KNOTS];
    logic [MAX_KNOTS-1:0]    r_valid;
    logic signed [HGT_W-1:0] r_rdata;
    logic                    r_rvld;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    // valid bits stand for the reset value of zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= 1'b1;
            r_rvld <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

/* src/lsfa_sum_mem.sv */
// ---------------------------------------------------------------------------
// lsfa_sum_mem: normal-equation sum memory
// Diagonal, off-diagonal and right-side sums per knot; clear through valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfa_sum_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_we,
    input  wire logic [lsfa_pkg::IDX_W-1:0] i_waddr,
    input  wire lsfa_pkg::t_sums            i_wdata,
    input  wire logic [lsfa_pkg::IDX_W-1:0] i_raddr,
    output lsfa_pkg::t_sums                 o_rdata
);
    import lsfa_pkg::*;

    t_sums                mem [MAX_KNOTS];
    logic [MAX_KNOTS-1:0] r_valid;
    t_sums                r_rdata;
    logic                 r_rvld;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    // valid bits: cleared entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvld <= r_valid[i_raddr] && !i_clear;
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

/* src/linear_spline_fit_accumulator.sv */
// ---------------------------------------------------------------------------
// linear_spline_fit_accumulator: linear spline least-squares accumulator
// Fits pixels against a piecewise-linear model and gathers normal equations.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when i_start is high and o_busy low.
//   i_action selects pixel, clear sums and count, load knot height or read knot sums.
//   Each item yields one result beat, shown for one cycle with o_done high;
//   the receiver cannot stall, so results must be captured on that cycle.
//   Config port: i_cfg_we / i_cfg_addr / i_cfg_data, written while idle.
// Work per item, from accept to o_done:
//   clear, load, pixel out of bounds: result set on accept.  read: S_RW, S_RD.
//   pixel in bounds: two serial 28-step divisions (segment and
//   hat weight), then the model multiplies and the read-modify-
//   write of the two knot entries in the sum memory.  A rejected pixel
//   ends after the tolerance compare, without the sum-memory writes.
// One item at a time: o_busy stays high until the result beat.
// Reset: config to defaults, knot heights, sums and point count to zero,
//   done through valid bits; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_spline_fit_accumulator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [1:0]                        i_action,
    input  wire logic [lsfa_pkg::COORD_BITS-1:0]   i_pixel_x,
    input  wire logic [lsfa_pkg::COORD_BITS-1:0]   i_pixel_y,
    input  wire logic [4:0]                        i_knot_index,
    input  wire logic signed [lsfa_pkg::HGT_W-1:0] i_knot_height,
    input  wire logic                              i_cfg_we,
    input  wire logic [lsfa_pkg::CFG_A_W-1:0]      i_cfg_addr,
    input  wire logic [lsfa_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                   o_done,
    output logic                                   o_accepted,
    output logic [lsfa_pkg::SUM_W-1:0]             o_diag_sum,
    output logic [lsfa_pkg::SUM_W-1:0]             o_offdiag_sum,
    output logic [lsfa_pkg::SUM_W-1:0]             o_rhs_sum,
    output logic [lsfa_pkg::CNT_W-1:0]             o_inlier_count
);
    import lsfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_D1S, S_D1W, S_OFF, S_D2S, S_D2W, S_H0, S_H1,
        S_DIFF, S_CMP, S_M1, S_M2, S_W0, S_M3, S_W1, S_RW, S_RD
    } t_state;

    // configuration registers
    logic [SP_W-1:0]       r_spacing;
    logic [IDX_W-1:0]      r_segments;
    logic [TOL_W-1:0]      r_tol;
    logic [COORD_BITS-1:0] r_xb;
    logic [COORD_BITS-1:0] r_yb;

    // item state
    t_state                r_state;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [IDX_W-1:0]      r_seg;
    logic [SP_W-1:0]       r_offs;
    logic [WGT_W-1:0]      r_bi;
    logic [WGT_W-1:0]      r_bj;
    logic signed [HGT_W+WGT_W:0] r_p0;
    logic signed [HGT_W+WGT_W:0] r_p1;
    logic signed [DIFF_W-1:0]    r_diff;
    logic [PRD_W-1:0]      r_pa;
    logic [PRD_W-1:0]      r_pb;
    logic [PRD_W-1:0]      r_pc;
    logic [CNT_W-1:0]      r_count;

    // result registers
    logic                  r_done;
    logic                  r_acc;
    logic [SUM_W-1:0]      r_dsum;
    logic [SUM_W-1:0]      r_osum;
    logic [SUM_W-1:0]      r_rsum;

    // effective spacing and segment count
    logic [SP_W-1:0]  sp_eff;
    logic [IDX_W-1:0] segs_eff;
    assign sp_eff   = (r_spacing == '0) ? SP_W'(1) : r_spacing;
    assign segs_eff = (r_segments == '0) ? IDX_W'(1) : r_segments;

    // divider
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic               div_busy;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic [SP_W-1:0]    div_rem;

    assign div_start    = (r_state == S_D1S) || (r_state == S_D2S);
    assign div_dividend = (r_state == S_D1S) ? DIV_W'(r_x) : {r_offs, 16'd0};

    lsfa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (sp_eff),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // knot heights
    logic                    knot_we;
    logic [IDX_W-1:0]        knot_raddr;
    logic signed [HGT_W-1:0] knot_rdata;

    assign knot_we    = (r_state == S_IDLE) && i_start && (i_action == ACT_LOAD);
    assign knot_raddr = (r_state == S_H0) ? r_seg + 1'b1 : r_seg;

    lsfa_knot_mem u_knot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (knot_we),
        .i_waddr (i_knot_index[IDX_W-1:0]),
        .i_wdata (i_knot_height),
        .i_raddr (knot_raddr),
        .o_rdata (knot_rdata)
    );

    // sum memory, read-modify-write of knots seg and seg+1
    logic             sum_clear;
    logic             sum_we;
    logic             second;
    logic [IDX_W-1:0] sum_addr;
    t_sums            sum_rd;
    t_sums            sum_wd;

    assign sum_clear = (r_state == S_IDLE) && i_start && (i_action == ACT_CLEAR);
    assign sum_we    = (r_state == S_W0) || (r_state == S_W1);
    assign second    = (r_state == S_W0) || (r_state == S_M3) || (r_state == S_W1);
    assign sum_addr  = (r_state == S_W1) ? r_seg + 1'b1 : r_seg;

    // write data: offdiag only moves for the first knot
    always_comb begin
        sum_wd.diag = sat_add(sum_rd.diag, r_pa);
        sum_wd.rhs  = sat_add(sum_rd.rhs, r_pc);
        sum_wd.offd = (r_state == S_W0) ? sat_add(sum_rd.offd, r_pb) : sum_rd.offd;
    end

    // read address moves to seg+1 while the first entry is written
    logic [IDX_W-1:0] sum_raddr;
    assign sum_raddr = second ? r_seg + 1'b1 : r_seg;

    lsfa_sum_mem u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (sum_clear),
        .i_we    (sum_we),
        .i_waddr (sum_addr),
        .i_wdata (sum_wd),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rd)
    );

    // datapath helpers
    logic [SP_W+IDX_W-1:0]  seg_base;
    logic [SP_W+IDX_W-1:0]  off_raw;
    logic [DIFF_W-1:0]      diff_abs;
    logic [DIFF_W-1:0]      tol_ext;
    logic [WGT_W-1:0]       bj_q;

    assign seg_base = r_seg * sp_eff;
    assign off_raw  = (SP_W+IDX_W)'(r_x) - seg_base;
    assign diff_abs = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign tol_ext  = DIFF_W'({r_tol, 16'd0});
    assign bj_q     = div_quo[WGT_W-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing  <= SP_W'(80);
            r_segments <= IDX_W'(16);
            r_tol      <= TOL_W'(256);
            r_xb       <= COORD_BITS'(1280);
            r_yb       <= COORD_BITS'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPACING:  r_spacing  <= i_cfg_data[SP_W-1:0];
                REG_SEGMENTS: r_segments <= i_cfg_data[IDX_W-1:0];
                REG_TOL:      r_tol      <= i_cfg_data[TOL_W-1:0];
                REG_XBOUND:   r_xb       <= i_cfg_data[COORD_BITS-1:0];
                REG_YBOUND:   r_yb       <= i_cfg_data[COORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer, datapath registers and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_acc   <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x    <= i_pixel_x;
                        r_y    <= i_pixel_y;
                        r_seg  <= i_knot_index[IDX_W-1:0];
                        r_acc  <= 1'b0;
                        r_dsum <= '0;
                        r_osum <= '0;
                        r_rsum <= '0;
                        case (i_action)
                            ACT_PIXEL: begin
                                if (i_pixel_x > r_xb || i_pixel_y > r_yb) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= S_D1S;
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_done  <= 1'b1;
                            end
                            ACT_LOAD: r_done <= 1'b1;
                            default:  r_state <= S_RW;
                        endcase
                    end
                end
                // read address settles on the requested knot
                S_RW: r_state <= S_RD;
                S_RD: begin
                    r_dsum  <= sum_rd.diag;
                    r_osum  <= sum_rd.offd;
                    r_rsum  <= sum_rd.rhs;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_D1S: r_state <= S_D1W;
                S_D1W: begin
                    if (div_done) begin
                        if (div_quo >= DIV_W'(segs_eff)) begin
                            r_seg   <= segs_eff - 1'b1;
                            r_state <= S_OFF;
                        end else begin
                            r_seg   <= div_quo[IDX_W-1:0];
                            r_offs  <= div_rem;
                            r_state <= S_D2S;
                        end
                    end
                end
                S_OFF: begin
                    r_offs  <= (off_raw > (SP_W+IDX_W)'(sp_eff)) ? sp_eff
                                                                 : off_raw[SP_W-1:0];
                    r_state <= S_D2S;
                end
                S_D2S: r_state <= S_D2W;
                S_D2W: begin
                    if (div_done) begin
                        r_bj    <= bj_q;
                        r_bi    <= WGT_W'(65536) - bj_q;
                        r_state <= S_H0;
                    end
                end
                S_H0: begin
                    r_p0    <= knot_rdata * $signed({1'b0, r_bi});
                    r_state <= S_H1;
                end
                S_H1: begin
                    r_p1    <= knot_rdata * $signed({1'b0, r_bj});
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= $signed({8'd0, r_y, 24'd0}) - DIFF_W'(r_p0) - DIFF_W'(r_p1);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_pa <= r_bi * r_bi;
                    if (diff_abs < tol_ext) begin
                        r_state <= S_M1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_M1: begin
                    r_pb    <= r_bi * r_bj;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_pc    <= PRD_W'(r_bi) * PRD_W'(r_y);
                    r_state <= S_W0;
                end
                S_W0: begin
                    r_pa    <= r_bj * r_bj;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_pc    <= PRD_W'(r_bj) * PRD_W'(r_y);
                    r_state <= S_W1;
                end
                S_W1: begin
                    if (r_count != {CNT_W{1'b1}}) r_count <= r_count + 1'b1;
                    r_acc   <= 1'b1;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_accepted     = r_acc;
    assign o_diag_sum     = r_dsum;
    assign o_offdiag_sum  = r_osum;
    assign o_rhs_sum      = r_rsum;
    assign o_inlier_count = r_count;

    // checks
    a_acc_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_accepted) |-> (o_inlier_count != '0))
        else $error("accepted pixel with zero count");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !div_busy)
        else $error("divider running while idle");

    a_write_in_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_we |-> (sum_addr == r_seg || sum_addr == IDX_W'(r_seg + 1'b1)))
        else $error("sum write outside the pixel's knots");

endmodule

`default_nettype wire
